/* rtl/fqrwl_pkg.sv */
// ----------------------------------------------------------------------------
// fqrwl_pkg
// Shared types, codes and constants for the fair queue reader-writer lock.
// ----------------------------------------------------------------------------
package fqrwl_pkg;

  localparam int NUM_REQUESTERS = 16;
  localparam int ID_W           = $clog2(NUM_REQUESTERS);
  localparam int LINK_W         = ID_W + 1;
  localparam int RID_W          = 4;
  localparam int MAX_RES        = 16;
  localparam int CNT_W          = $clog2(MAX_RES + 1);

  typedef logic [LINK_W-1:0] link_t;

  localparam link_t NIL_LINK = LINK_W'(NUM_REQUESTERS);

  typedef enum logic [1:0] {
    CMD_RD_LOCK   = 2'd0,
    CMD_RD_UNLOCK = 2'd1,
    CMD_WR_LOCK   = 2'd2,
    CMD_WR_UNLOCK = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ROLE_IDLE   = 3'd0,
    ROLE_WAIT_R = 3'd1,
    ROLE_ACT_R  = 3'd2,
    ROLE_WAIT_W = 3'd3,
    ROLE_ACT_W  = 3'd4
  } role_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ENQ,
    S_UNLINK,
    S_POP,
    S_HAND
  } state_t;

  typedef struct packed {
    logic             status;
    logic             grant_valid;
    logic [RID_W-1:0] grant_id;
    logic             grant_is_writer;
    logic             last;
  } result_t;

  function automatic logic is_node(link_t x);
    return x < LINK_W'(NUM_REQUESTERS);
  endfunction

endpackage

/* rtl/fqrwl_if.sv */
// ----------------------------------------------------------------------------
// fqrwl_cmd_if / fqrwl_res_if
// Valid-ready channels for lock commands and lock results.
// ----------------------------------------------------------------------------
interface fqrwl_cmd_if;
  logic                        valid;
  logic                        ready;
  fqrwl_pkg::cmd_t             cmd;
  logic [fqrwl_pkg::RID_W-1:0] requester_id;

  modport source (output valid, output cmd, output requester_id, input ready);
  modport sink   (input valid, input cmd, input requester_id, output ready);
endinterface

interface fqrwl_res_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic                        grant_valid;
  logic [fqrwl_pkg::RID_W-1:0] grant_id;
  logic                        grant_is_writer;
  logic                        last;

  modport source (output valid, output status, output grant_valid, output grant_id,
                  output grant_is_writer, output last, input ready);
  modport sink   (input valid, input status, input grant_valid, input grant_id,
                  input grant_is_writer, input last, output ready);
endinterface

/* rtl/fair_queue_rw_lock_arbiter_core.sv */
// ----------------------------------------------------------------------------
// fair_queue_rw_lock_arbiter_core
// FIFO-fair reader-writer lock manager over a doubly linked waiter queue.
// ----------------------------------------------------------------------------
// Lock: S_CHECK on an empty queue, else S_CHECK, S_ENQ; reader unlink: S_CHECK, S_UNLINK.
// Release by the head: S_CHECK, S_POP, then S_HAND, repeated for each reader granted.
// Each link/role store has one write port and one registered read port.
// The next command is taken the cycle after the final result enters the output register.
// Synchronous reset clears the sequencer, head, tail and the per-entry valid bits,
// so every entry reads as null links and idle role at once; no clearing pass.
module fair_queue_rw_lock_arbiter_core (
  input logic         clk,
  input logic         rst,
  fqrwl_cmd_if.sink   req,
  fqrwl_res_if.source res
);

  localparam int NR    = fqrwl_pkg::NUM_REQUESTERS;
  localparam int ID_W  = fqrwl_pkg::ID_W;
  localparam int RID_W = fqrwl_pkg::RID_W;
  localparam int CNT_W = fqrwl_pkg::CNT_W;

  fqrwl_pkg::state_t  state, state_next;
  fqrwl_pkg::cmd_t    cmd_r, cmd_next;
  logic [RID_W-1:0]   id_r, id_next;
  fqrwl_pkg::link_t   head, head_next;
  fqrwl_pkg::link_t   tail, tail_next;
  fqrwl_pkg::link_t   x_r, x_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic               pend_v, pend_v_next;
  logic [ID_W-1:0]    pend_id, pend_id_next;

  fqrwl_pkg::link_t   nmem [NR];
  fqrwl_pkg::link_t   pmem [NR];
  fqrwl_pkg::role_t   rmem [NR];
  logic [NR-1:0]      nvld, pvld, rvld;
  fqrwl_pkg::link_t   rd_next, rd_prev;
  fqrwl_pkg::role_t   rd_role;
  logic [ID_W-1:0]    raddr;

  logic               nwe, pwe, rwe;
  logic [ID_W-1:0]    nwa, pwa, rwa;
  fqrwl_pkg::link_t   nwd, pwd;
  fqrwl_pkg::role_t   rwd;

  logic               out_valid;
  fqrwl_pkg::result_t out_res;
  logic               push;
  fqrwl_pkg::result_t push_res;
  logic               slot;

  logic               in_range, is_lock, is_reader, ok;
  logic [ID_W-1:0]    id_idx;
  fqrwl_pkg::link_t   id_link;

  assign id_idx    = ID_W'(id_r);
  assign id_link   = fqrwl_pkg::LINK_W'(id_r);
  assign in_range  = int'(id_r) < NR;
  assign is_lock   = (cmd_r == fqrwl_pkg::CMD_RD_LOCK) || (cmd_r == fqrwl_pkg::CMD_WR_LOCK);
  assign is_reader = (cmd_r == fqrwl_pkg::CMD_RD_LOCK);
  assign ok = in_range && (is_lock ? (rd_role == fqrwl_pkg::ROLE_IDLE) :
              (cmd_r == fqrwl_pkg::CMD_RD_UNLOCK) ? (rd_role == fqrwl_pkg::ROLE_ACT_R) :
                                                  (rd_role == fqrwl_pkg::ROLE_ACT_W));
  assign slot      = !out_valid || res.ready;
  assign req.ready = (state == fqrwl_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= fqrwl_pkg::S_IDLE;
      head   <= fqrwl_pkg::NIL_LINK;
      tail   <= fqrwl_pkg::NIL_LINK;
      cnt    <= '0;
      pend_v <= 1'b0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      tail   <= tail_next;
      cnt    <= cnt_next;
      pend_v <= pend_v_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_next;
    id_r    <= id_next;
    x_r     <= x_next;
    pend_id <= pend_id_next;
  end

  always_comb begin
    state_next   = state;
    cmd_next     = cmd_r;
    id_next      = id_r;
    head_next    = head;
    tail_next    = tail;
    x_next       = x_r;
    cnt_next     = cnt;
    pend_v_next  = pend_v;
    pend_id_next = pend_id;
    nwe          = 1'b0;
    nwa          = id_idx;
    nwd          = fqrwl_pkg::NIL_LINK;
    pwe          = 1'b0;
    pwa          = id_idx;
    pwd          = fqrwl_pkg::NIL_LINK;
    rwe          = 1'b0;
    rwa          = id_idx;
    rwd          = fqrwl_pkg::ROLE_IDLE;
    push         = 1'b0;
    push_res     = '0;
    case (state)
      fqrwl_pkg::S_IDLE: begin
        if (req.valid) begin
          cmd_next   = req.cmd;
          id_next    = req.requester_id;
          state_next = fqrwl_pkg::S_CHECK;
        end
      end
      fqrwl_pkg::S_CHECK: begin
        if (slot) begin
          cnt_next    = '0;
          pend_v_next = 1'b0;
          if (!ok) begin
            push            = 1'b1;
            push_res.status = 1'b1;
            push_res.last   = 1'b1;
            state_next      = fqrwl_pkg::S_IDLE;
          end else if (is_lock) begin
            nwe = 1'b1;
            if (!fqrwl_pkg::is_node(tail)) begin
              pwe                      = 1'b1;
              rwe                      = 1'b1;
              rwd                      = is_reader ? fqrwl_pkg::ROLE_ACT_R :
                                                     fqrwl_pkg::ROLE_ACT_W;
              head_next                = id_link;
              tail_next                = id_link;
              push                     = 1'b1;
              push_res.grant_valid     = 1'b1;
              push_res.grant_id        = id_r;
              push_res.grant_is_writer = !is_reader;
              push_res.last            = 1'b1;
              state_next               = fqrwl_pkg::S_IDLE;
            end else begin
              state_next = fqrwl_pkg::S_ENQ;
            end
          end else if (cmd_r == fqrwl_pkg::CMD_RD_UNLOCK && fqrwl_pkg::is_node(rd_prev)) begin
            nwe = 1'b1;
            nwa = rd_prev[ID_W-1:0];
            nwd = rd_next;
            if (fqrwl_pkg::is_node(rd_next)) begin
              pwe = 1'b1;
              pwa = rd_next[ID_W-1:0];
              pwd = rd_prev;
            end else begin
              tail_next = rd_prev;
            end
            rwe        = 1'b1;
            state_next = fqrwl_pkg::S_UNLINK;
          end else begin
            head_next = rd_next;
            if (fqrwl_pkg::is_node(rd_next)) begin
              pwe = 1'b1;
              pwa = rd_next[ID_W-1:0];
            end else begin
              tail_next = fqrwl_pkg::NIL_LINK;
            end
            nwe        = 1'b1;
            rwe        = 1'b1;
            x_next     = rd_next;
            state_next = fqrwl_pkg::S_POP;
          end
        end
      end
      fqrwl_pkg::S_ENQ: begin
        if (slot) begin
          pwe       = 1'b1;
          pwd       = tail;
          nwe       = 1'b1;
          nwa       = tail[ID_W-1:0];
          nwd       = id_link;
          tail_next = id_link;
          rwe       = 1'b1;
          push      = 1'b1;
          push_res.last = 1'b1;
          if (is_reader && rd_role == fqrwl_pkg::ROLE_ACT_R) begin
            rwd                  = fqrwl_pkg::ROLE_ACT_R;
            push_res.grant_valid = 1'b1;
            push_res.grant_id    = id_r;
          end else begin
            rwd = is_reader ? fqrwl_pkg::ROLE_WAIT_R : fqrwl_pkg::ROLE_WAIT_W;
          end
          state_next = fqrwl_pkg::S_IDLE;
        end
      end
      fqrwl_pkg::S_UNLINK: begin
        if (slot) begin
          nwe           = 1'b1;
          pwe           = 1'b1;
          push          = 1'b1;
          push_res.last = 1'b1;
          state_next    = fqrwl_pkg::S_IDLE;
        end
      end
      fqrwl_pkg::S_POP: begin
        pwe        = 1'b1;
        state_next = fqrwl_pkg::S_HAND;
      end
      fqrwl_pkg::S_HAND: begin
        if (slot) begin
          rwa = x_r[ID_W-1:0];
          if (fqrwl_pkg::is_node(x_r) && cnt == '0 && rd_role == fqrwl_pkg::ROLE_WAIT_W) begin
            rwe                      = 1'b1;
            rwd                      = fqrwl_pkg::ROLE_ACT_W;
            push                     = 1'b1;
            push_res.grant_valid     = 1'b1;
            push_res.grant_id        = RID_W'(x_r[ID_W-1:0]);
            push_res.grant_is_writer = 1'b1;
            push_res.last            = 1'b1;
            state_next               = fqrwl_pkg::S_IDLE;
          end else if (fqrwl_pkg::is_node(x_r) && rd_role == fqrwl_pkg::ROLE_WAIT_R &&
                       cnt < CNT_W'(fqrwl_pkg::MAX_RES)) begin
            rwe = 1'b1;
            rwd = fqrwl_pkg::ROLE_ACT_R;
            if (pend_v) begin
              push                 = 1'b1;
              push_res.grant_valid = 1'b1;
              push_res.grant_id    = RID_W'(pend_id);
            end
            pend_v_next  = 1'b1;
            pend_id_next = x_r[ID_W-1:0];
            cnt_next     = cnt + CNT_W'(1);
            x_next       = rd_next;
          end else begin
            push          = 1'b1;
            push_res.last = 1'b1;
            if (pend_v) begin
              push_res.grant_valid = 1'b1;
              push_res.grant_id    = RID_W'(pend_id);
            end
            pend_v_next = 1'b0;
            state_next  = fqrwl_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = fqrwl_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    case (state_next)
      fqrwl_pkg::S_CHECK: raddr = ID_W'(id_next);
      fqrwl_pkg::S_ENQ:   raddr = tail[ID_W-1:0];
      default:            raddr = x_next[ID_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (nwe) begin
      nmem[nwa] <= nwd;
    end
    if (pwe) begin
      pmem[pwa] <= pwd;
    end
    if (rwe) begin
      rmem[rwa] <= rwd;
    end
    rd_next <= nvld[raddr] ? nmem[raddr] : fqrwl_pkg::NIL_LINK;
    rd_prev <= pvld[raddr] ? pmem[raddr] : fqrwl_pkg::NIL_LINK;
    rd_role <= rvld[raddr] ? rmem[raddr] : fqrwl_pkg::ROLE_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nvld <= '0;
      pvld <= '0;
      rvld <= '0;
    end else begin
      if (nwe) begin
        nvld[nwa] <= 1'b1;
      end
      if (pwe) begin
        pvld[pwa] <= 1'b1;
      end
      if (rwe) begin
        rvld[rwa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res <= push_res;
    end
  end

  assign res.valid           = out_valid;
  assign res.status          = out_res.status;
  assign res.grant_valid     = out_res.grant_valid;
  assign res.grant_id        = out_res.grant_id;
  assign res.grant_is_writer = out_res.grant_is_writer;
  assign res.last            = out_res.last;

  a_head_tail_empty: assert property (@(posedge clk) disable iff (rst)
    fqrwl_pkg::is_node(head) == fqrwl_pkg::is_node(tail))
    else $error("head and tail disagree on queue empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(fqrwl_pkg::MAX_RES))
    else $error("grant chain count out of bound");

  a_error_result: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status |-> !res.grant_valid && res.last)
    else $error("error result carries a grant or is not last");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("command taken while previous command in progress");

endmodule

/* tb/fair_queue_rw_lock_arbiter_checker.sv */
// ----------------------------------------------------------------------------
// fair_queue_rw_lock_arbiter_checker
// Watches the command and result channels of the lock manager. Each accepted
// command is run through a local copy of the waiter queue (links, roles, head,
// tail) to work out the result transfers it must cause. Each result transfer
// is then compared, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module fair_queue_rw_lock_arbiter_checker
  import fqrwl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  fqrwl_cmd_if  req,
  fqrwl_res_if  res,
  output int    fail_count,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  link_t   nxt_of  [NUM_REQUESTERS];
  link_t   prv_of  [NUM_REQUESTERS];
  role_t   role_of [NUM_REQUESTERS];
  link_t   head_l;
  link_t   tail_l;
  result_t lock_results_q[$];

  function automatic bit linked(link_t x);
    return x < NIL_LINK;
  endfunction

  function automatic result_t lock_result(logic st, logic gv, logic [RID_W-1:0] gid,
                                          logic gw);
    result_t r;
    r.status          = st;
    r.grant_valid     = gv;
    r.grant_id        = gid;
    r.grant_is_writer = gw;
    r.last            = 1'b0;
    return r;
  endfunction

  function automatic void apply_lock_cmd(cmd_t op, logic [RID_W-1:0] rid);
    result_t batch[$];
    result_t r;
    link_t   who;
    link_t   p;
    link_t   nx;
    link_t   cur;
    bit      allowed;
    who = link_t'(rid);
    allowed = 1'b0;
    if (int'(rid) < NUM_REQUESTERS) begin
      case (op)
        CMD_RD_LOCK, CMD_WR_LOCK: allowed = (role_of[who] == ROLE_IDLE);
        CMD_RD_UNLOCK:            allowed = (role_of[who] == ROLE_ACT_R);
        default:                  allowed = (role_of[who] == ROLE_ACT_W);
      endcase
    end
    if (!allowed) begin
      batch.push_back(lock_result(1'b1, 1'b0, '0, 1'b0));
    end else if (op == CMD_RD_LOCK || op == CMD_WR_LOCK) begin
      p = tail_l;
      nxt_of[who] = NIL_LINK;
      prv_of[who] = NIL_LINK;
      if (!linked(p)) begin
        head_l = who;
        tail_l = who;
        if (op == CMD_RD_LOCK) role_of[who] = ROLE_ACT_R;
        else role_of[who] = ROLE_ACT_W;
        batch.push_back(lock_result(1'b0, 1'b1, rid, op == CMD_WR_LOCK));
      end else begin
        prv_of[who] = p;
        nxt_of[p]   = who;
        tail_l      = who;
        if (op == CMD_RD_LOCK && role_of[p] == ROLE_ACT_R) begin
          role_of[who] = ROLE_ACT_R;
          batch.push_back(lock_result(1'b0, 1'b1, rid, 1'b0));
        end else if (op == CMD_RD_LOCK) begin
          role_of[who] = ROLE_WAIT_R;
        end else begin
          role_of[who] = ROLE_WAIT_W;
        end
      end
    end else if (op == CMD_RD_UNLOCK && linked(prv_of[who])) begin
      // unlink from the middle or tail, no grant
      p  = prv_of[who];
      nx = nxt_of[who];
      nxt_of[p] = nx;
      if (linked(nx)) prv_of[nx] = p;
      else tail_l = p;
      nxt_of[who]  = NIL_LINK;
      prv_of[who]  = NIL_LINK;
      role_of[who] = ROLE_IDLE;
    end else begin
      // pop the head and hand the lock to the next waiting writer or run of waiting readers
      nx = nxt_of[who];
      head_l = nx;
      if (linked(nx)) prv_of[nx] = NIL_LINK;
      else tail_l = NIL_LINK;
      nxt_of[who]  = NIL_LINK;
      prv_of[who]  = NIL_LINK;
      role_of[who] = ROLE_IDLE;
      if (linked(nx) && role_of[nx] == ROLE_WAIT_W) begin
        role_of[nx] = ROLE_ACT_W;
        batch.push_back(lock_result(1'b0, 1'b1, nx[RID_W-1:0], 1'b1));
      end else begin
        cur = nx;
        while (linked(cur) && role_of[cur] == ROLE_WAIT_R && batch.size() < MAX_RES) begin
          role_of[cur] = ROLE_ACT_R;
          batch.push_back(lock_result(1'b0, 1'b1, cur[RID_W-1:0], 1'b0));
          cur = nxt_of[cur];
        end
      end
    end
    if (batch.size() == 0) batch.push_back(lock_result(1'b0, 1'b0, '0, 1'b0));
    r = batch.pop_back();
    r.last = 1'b1;
    batch.push_back(r);
    foreach (batch[i]) lock_results_q.push_back(batch[i]);
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      for (int i = 0; i < NUM_REQUESTERS; i++) begin
        nxt_of[i]  = NIL_LINK;
        prv_of[i]  = NIL_LINK;
        role_of[i] = ROLE_IDLE;
      end
      head_l = NIL_LINK;
      tail_l = NIL_LINK;
      lock_results_q.delete();
      fail_count = 0;
    end else begin
      if (req.valid && req.ready) apply_lock_cmd(req.cmd, req.requester_id);
      if (res.valid && res.ready) begin
        got.status          = res.status;
        got.grant_valid     = res.grant_valid;
        got.grant_id        = res.grant_id;
        got.grant_is_writer = res.grant_is_writer;
        got.last            = res.last;
        if (lock_results_q.size() == 0) begin
          $display("%0t: unexpected result transfer: st=%0b gv=%0b id=%0d wr=%0b last=%0b",
                   $time, got.status, got.grant_valid, got.grant_id,
                   got.grant_is_writer, got.last);
          fail_count++;
        end else begin
          want = lock_results_q.pop_front();
          if (got.status !== want.status || got.grant_valid !== want.grant_valid ||
              got.grant_id !== want.grant_id ||
              got.grant_is_writer !== want.grant_is_writer || got.last !== want.last) begin
            $display("%0t: result mismatch: expected st=%0b gv=%0b id=%0d wr=%0b last=%0b",
                     $time, want.status, want.grant_valid, want.grant_id,
                     want.grant_is_writer, want.last);
            $display("%0t:                  actual   st=%0b gv=%0b id=%0d wr=%0b last=%0b",
                     $time, got.status, got.grant_valid, got.grant_id,
                     got.grant_is_writer, got.last);
            fail_count++;
          end
        end
      end
    end
    pending = lock_results_q.size();
  end

endmodule

/* tb/fair_queue_rw_lock_arbiter_core_tb.sv */
// ----------------------------------------------------------------------------
// fair_queue_rw_lock_arbiter_core_tb
// Drives lock and unlock commands into the lock manager and stalls its result
// channel at random. A directed sequence covers grants, waits, chained reader
// grants, middle unlinks and misuse; a long reader chain follows; then random
// traffic keeps a shadow of the queue order so that most commands are legal,
// with misuse mixed in. The checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module fair_queue_rw_lock_arbiter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fqrwl_pkg::*;

  typedef struct {
    logic [RID_W-1:0] id;
    bit               wr;
  } holder_t;

  logic    clk = 1'b0;
  logic    rst;
  bit      req_xfer;
  bit      calm;
  int      fail_count;
  int      pending;
  int      ready_left;
  holder_t line_q[$];

  fqrwl_cmd_if req_ch ();
  fqrwl_res_if res_ch ();

  fair_queue_rw_lock_arbiter_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  fair_queue_rw_lock_arbiter_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) req_xfer <= req_ch.valid && req_ch.ready;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (calm) begin
      res_ch.ready <= 1'b1;
      ready_left = 0;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if ($urandom_range(0, 1) == 0) begin
      res_ch.ready <= 1'b1;
      ready_left = $urandom_range(0, 6);
    end else begin
      res_ch.ready <= 1'b0;
      ready_left = idle_len();
    end
  end

  task automatic issue(cmd_t op, logic [RID_W-1:0] rid);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= op;
    req_ch.requester_id <= rid;
    do @(negedge clk); while (!req_xfer);
  endtask

  function automatic int slot_of(logic [RID_W-1:0] rid);
    foreach (line_q[i]) if (line_q[i].id == rid) return i;
    return -1;
  endfunction

  // holders: a writer at the head, or the run of readers from the head
  function automatic int active_count();
    int n;
    n = 0;
    if (line_q.size() == 0) return 0;
    if (line_q[0].wr) return 1;
    while (n < line_q.size() && !line_q[n].wr) n++;
    return n;
  endfunction

  function automatic logic [RID_W-1:0] idle_id();
    logic [RID_W-1:0] rid;
    do rid = $urandom_range(0, NUM_REQUESTERS - 1); while (slot_of(rid) >= 0);
    return rid;
  endfunction

  task automatic random_step();
    int      act;
    int      pick;
    int      variant;
    int      k;
    holder_t h;
    act  = active_count();
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      variant = $urandom_range(0, 3);
      if (line_q.size() == 0) variant = 3;
      if (variant == 2 && line_q.size() == act) variant = 1;
      if (variant == 3 && line_q.size() == NUM_REQUESTERS) variant = 0;
      case (variant)
        0: begin
          h = line_q[$urandom_range(0, line_q.size() - 1)];
          issue($urandom_range(0, 1) ? CMD_WR_LOCK : CMD_RD_LOCK, h.id);
        end
        1: begin
          h = line_q[$urandom_range(0, act - 1)];
          issue(h.wr ? CMD_RD_UNLOCK : CMD_WR_UNLOCK, h.id);
        end
        2: begin
          h = line_q[$urandom_range(act, line_q.size() - 1)];
          issue($urandom_range(0, 1) ? CMD_WR_UNLOCK : CMD_RD_UNLOCK, h.id);
        end
        default: issue($urandom_range(0, 1) ? CMD_WR_UNLOCK : CMD_RD_UNLOCK, idle_id());
      endcase
    end else if (line_q.size() < NUM_REQUESTERS && (line_q.size() == 0 || pick < 60)) begin
      h.id = idle_id();
      h.wr = ($urandom_range(0, 99) < 30);
      issue(h.wr ? CMD_WR_LOCK : CMD_RD_LOCK, h.id);
      line_q.push_back(h);
    end else begin
      k = $urandom_range(0, act - 1);
      h = line_q[k];
      issue(h.wr ? CMD_WR_UNLOCK : CMD_RD_UNLOCK, h.id);
      line_q.delete(k);
    end
  endtask

  initial begin
    logic [RID_W-1:0] readers_q[$];
    int               k;
    rst                 = 1'b1;
    calm                = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.cmd          = CMD_RD_LOCK;
    req_ch.requester_id = '0;
    res_ch.ready        = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    issue(CMD_WR_LOCK,   4'd0);
    issue(CMD_RD_LOCK,   4'd15);
    issue(CMD_RD_LOCK,   4'd7);
    issue(CMD_WR_LOCK,   4'd3);
    issue(CMD_RD_LOCK,   4'd9);
    issue(CMD_RD_LOCK,   4'd0);
    issue(CMD_WR_UNLOCK, 4'd15);
    issue(CMD_RD_UNLOCK, 4'd0);
    issue(CMD_WR_UNLOCK, 4'd0);
    issue(CMD_RD_UNLOCK, 4'd7);
    issue(CMD_RD_LOCK,   4'd12);
    issue(CMD_RD_UNLOCK, 4'd15);
    issue(CMD_WR_UNLOCK, 4'd3);
    issue(CMD_RD_LOCK,   4'd5);
    issue(CMD_RD_UNLOCK, 4'd9);
    issue(CMD_RD_UNLOCK, 4'd5);
    issue(CMD_RD_UNLOCK, 4'd12);
    issue(CMD_WR_UNLOCK, 4'd12);
    issue(CMD_WR_LOCK,   4'd10);
    issue(CMD_WR_LOCK,   4'd10);
    issue(CMD_WR_UNLOCK, 4'd10);

    issue(CMD_WR_LOCK, 4'd15);
    for (int i = 0; i < NUM_REQUESTERS - 1; i++) begin
      issue(CMD_RD_LOCK, RID_W'(i));
      readers_q.push_back(RID_W'(i));
    end
    issue(CMD_WR_UNLOCK, 4'd15);
    while (readers_q.size() > 0) begin
      k = $urandom_range(0, readers_q.size() - 1);
      issue(CMD_RD_UNLOCK, readers_q[k]);
      readers_q.delete(k);
    end

    for (int n = 0; n < 97; n++) begin
      calm <= ((n / 40) % 2 == 1);
      random_step();
    end
    req_ch.valid <= 1'b0;
    calm         <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* fair_queue_rw_lock_arbiter_core.f */
rtl/fqrwl_pkg.sv
rtl/fqrwl_if.sv
rtl/fair_queue_rw_lock_arbiter_core.sv
tb/fair_queue_rw_lock_arbiter_checker.sv
tb/fair_queue_rw_lock_arbiter_core_tb.sv
